### hw/rtl/wavetable_oscillator_interp_macros.svh
// ----------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Shared concurrent assertion templates.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_INTERP_MACROS_SVH
`define WAVETABLE_OSCILLATOR_INTERP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define WTO_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define WTO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/wto_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Widths, op codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package wto_pkg;

    localparam int TABLE_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int PHASE_BITS  = TABLE_BITS + FRAC_BITS;
    localparam int WAVE_DEPTH  = 1 << TABLE_BITS;
    localparam int STEP_LIMIT  = WAVE_DEPTH / 2;
    localparam int INDEX_W     = 10;
    localparam int VALUE_W     = 16;
    localparam int AMP_W       = 16;
    localparam int AMP_FRAC    = 12;
    localparam int SAMPLE_W    = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 26;

    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(4096);

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD   = 2'd0;
    localparam t_op OP_SET    = 2'd1;
    localparam t_op OP_SAMPLE = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_PHASE_STEP = 1'd0;
    localparam t_cfg_idx REG_AMPLITUDE  = 1'd1;

endpackage

`default_nettype wire

### hw/rtl/wto_if.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator channels
// Input item, result item and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface wto_in_if import wto_pkg::*; ();
    logic                        valid;
    logic                        ready;
    t_op                         op;
    logic [INDEX_W-1:0]          table_index;
    logic signed [VALUE_W-1:0]   table_value;
    logic [PHASE_BITS-1:0]       start_phase;
    logic signed [SAMPLE_W-1:0]  accum_in;

    modport source (output valid, op, table_index, table_value, start_phase, accum_in,
                    input ready);
    modport sink   (input valid, op, table_index, table_value, start_phase, accum_in,
                    output ready);
endinterface

interface wto_out_if import wto_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic signed [SAMPLE_W-1:0]  peak;
    logic [PHASE_BITS-1:0]       phase_out;
    logic                        step_error;

    modport source (output valid, sample_out, peak, phase_out, step_error, input ready);
    modport sink   (input valid, sample_out, peak, phase_out, step_error, output ready);
endinterface

interface wto_cfg_if import wto_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_cfg_idx               index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/wavetable_oscillator_interp.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator with linear interpolation
// Table load, phase set and interpolated, scaled, saturated sample items.
// ----------------------------------------------------------------------------
// One item is in work at a time. A load or phase-set item goes from
// acceptance straight to the final state, then to the result register; a
// sample item that advances the phase first makes two back-to-back reads of
// the table's single read port, then the interpolation and gain multiplies.
// A sample item with a zero step, zero amplitude or an out-of-range step
// goes straight to the final state as well. The result register lets the
// next item enter while a result waits; a result is held in its final state
// only while that register is still full. Register writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wavetable_oscillator_interp_macros.svh"

module wavetable_oscillator_interp import wto_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    wto_in_if.sink        i_in,
    wto_out_if.source     o_out,
    wto_cfg_if.sink       i_cfg
);

    localparam int PROD1_W = VALUE_W + 1 + FRAC_BITS + 1;
    localparam int VAL_W   = VALUE_W + 1;
    localparam int PROD2_W = VAL_W + AMP_W + 1;
    localparam int SCL_W   = PROD2_W - AMP_FRAC;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD1  = 5'b00010,
        S_MUL1 = 5'b00100,
        S_MUL2 = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    logic signed [VALUE_W-1:0] r_mem [WAVE_DEPTH];

    t_state                      r_state, n_state;
    logic [PHASE_BITS-1:0]       r_step;
    logic [AMP_W-1:0]            r_amp;
    logic [PHASE_BITS-1:0]       r_phase;
    logic signed [SAMPLE_W-1:0]  r_peak;
    t_op                         r_op;
    logic signed [SAMPLE_W-1:0]  r_accum;
    logic                        r_active;
    logic                        r_err;
    logic signed [VALUE_W-1:0]   r_rdata;
    logic signed [VALUE_W-1:0]   r_v0;
    logic signed [PROD1_W-1:0]   r_prod1;
    logic signed [PROD2_W-1:0]   r_prod2;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_sample_out;
    logic signed [SAMPLE_W-1:0]  r_peak_out;
    logic [PHASE_BITS-1:0]       r_phase_out;
    logic                        r_err_out;

    logic                        in_fire;
    logic                        done_fire;
    logic                        err_now;
    logic                        active_now;
    logic [TABLE_BITS-1:0]       rd_addr;
    logic signed [VALUE_W:0]     delta;
    logic signed [VAL_W:0]       val_wide;
    logic signed [VAL_W-1:0]     val;
    logic signed [SCL_W-1:0]     scaled;
    logic signed [SAMPLE_W:0]    sum;
    logic signed [SAMPLE_W-1:0]  sat;
    logic signed [SAMPLE_W-1:0]  res_sample;
    logic signed [SAMPLE_W-1:0]  n_peak;
    logic [PHASE_BITS-1:0]       n_phase;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign done_fire   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign err_now    = (r_step[PHASE_BITS-1:FRAC_BITS] > TABLE_BITS'(STEP_LIMIT));
    assign active_now = (i_in.op == OP_SAMPLE) && !err_now && (r_step != '0)
                        && (r_amp != '0);

    assign rd_addr = r_phase[PHASE_BITS-1:FRAC_BITS]
                     + TABLE_BITS'(r_state == S_RD1);

    // Interpolation and gain datapath
    assign delta    = {r_rdata[VALUE_W-1], r_rdata} - {r_v0[VALUE_W-1], r_v0};
    assign val_wide = {{2{r_v0[VALUE_W-1]}}, r_v0} + r_prod1[PROD1_W-1:FRAC_BITS];
    assign val      = val_wide[VAL_W-1:0];
    assign scaled   = r_prod2[PROD2_W-1:AMP_FRAC];
    assign sum      = {r_accum[SAMPLE_W-1], r_accum}
                      + (SAMPLE_W+1)'(scaled);

    always_comb begin
        if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
            sat = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            sat = sum[SAMPLE_W-1:0];
        end
        if (r_active) begin
            res_sample = sat;
        end else if (r_op == OP_SAMPLE) begin
            res_sample = r_accum;
        end else begin
            res_sample = '0;
        end
        n_peak  = (r_active && (sat > r_peak)) ? sat : r_peak;
        n_phase = r_active ? (r_phase + r_step) : r_phase;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = active_now ? S_RD1 : S_DONE;
                end
            end
            S_RD1:  n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DONE;
            S_DONE: begin
                if (done_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Table memory
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.op == OP_LOAD)) begin
            r_mem[i_in.table_index[TABLE_BITS-1:0]] <= i_in.table_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_amp       <= AMP_RESET;
            r_phase     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_PHASE_STEP: r_step <= i_cfg.data[PHASE_BITS-1:0];
                    REG_AMPLITUDE:  r_amp  <= i_cfg.data[AMP_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire && (i_in.op == OP_SET)) begin
                r_phase <= i_in.start_phase;
            end else if (done_fire) begin
                r_phase <= n_phase;
            end
            if (done_fire) begin
                r_peak <= n_peak;
            end
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= i_in.op;
            r_accum  <= i_in.accum_in;
            r_active <= active_now;
            r_err    <= err_now;
        end
        if (r_state == S_RD1) begin
            r_v0 <= r_rdata;
        end
        if (r_state == S_MUL1) begin
            r_prod1 <= PROD1_W'(delta * $signed({1'b0, r_phase[FRAC_BITS-1:0]}));
        end
        if (r_state == S_MUL2) begin
            r_prod2 <= PROD2_W'(val * $signed({1'b0, r_amp}));
        end
        if (done_fire) begin
            r_sample_out <= res_sample;
            r_peak_out   <= n_peak;
            r_phase_out  <= n_phase;
            r_err_out    <= r_err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_sample_out;
    assign o_out.peak       = r_peak_out;
    assign o_out.phase_out  = r_phase_out;
    assign o_out.step_error = r_err_out;

    `WTO_ASSERT_NEXT(a_sample_reads, i_clk, i_rst_n, in_fire && active_now, r_state == S_RD1, "sample item did not start table read")
    `WTO_ASSERT_IMPL(a_peak_mono, i_clk, i_rst_n, $past(i_rst_n), r_peak >= $past(r_peak), "peak decreased")
    `WTO_ASSERT_IMPL(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_DONE), "result loaded outside final state")
    `WTO_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, (r_state == S_RD1) || (r_state == S_MUL1), $stable(r_phase), "phase changed during table read")

endmodule

`default_nettype wire

### bench/wavetable_oscillator_interp_tb.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator testbench
// Drives table loads, phase sets and sample items with random gaps and output
// stalls, steps through several step and gain settings, and checks each result
// against fixed values or an in-bench model of the interpolating oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_oscillator_interp_tb;
    import wto_pkg::*;

    localparam t_op     OP_UNUSED       = 2'd3;
    localparam int      WATCHDOG_LIMIT  = 1000;
    localparam int      SETTLE_CYCLES   = 8;
    localparam int      MAX_REPORTS     = 10;
    localparam int      RAND_PHASES     = 10;
    localparam int      ITEMS_PER_PHASE = 200;
    localparam longint  SAT_HI          = 64'sh0000_0000_7FFF_FFFF;
    localparam longint  SAT_LO          = -64'sh0000_0000_8000_0000;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic signed [SAMPLE_W-1:0] peak;
        logic [PHASE_BITS-1:0]      phase_out;
        logic                       step_error;
    } t_osc_result;

    typedef struct packed {
        t_row_kind                  kind;
        t_cfg_idx                   reg_idx;
        logic [CFG_DATA_W-1:0]      data;
        t_op                        op;
        logic [INDEX_W-1:0]         idx;
        logic signed [VALUE_W-1:0]  value;
        logic [PHASE_BITS-1:0]      start;
        logic signed [SAMPLE_W-1:0] accum;
        logic                       typed;
        t_osc_result                want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wto_in_if  in_if ();
    wto_out_if out_if ();
    wto_cfg_if cfg_if ();

    wavetable_oscillator_interp u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // oscillator model state
    logic signed [VALUE_W-1:0]  wave_mem [WAVE_DEPTH];
    bit                         wave_known [WAVE_DEPTH];
    logic [PHASE_BITS-1:0]      osc_phase = '0;
    logic signed [SAMPLE_W-1:0] osc_peak  = '0;
    logic [PHASE_BITS-1:0]      osc_step  = '0;
    logic [AMP_W-1:0]           osc_gain  = AMP_RESET;

    t_osc_result osc_outputs_due [$];
    t_stim_row   dir_rows [$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    int          send_burst  = 0;
    int          take_burst  = 0;

    function automatic logic osc_reads_table();
        return (osc_step >> FRAC_BITS) <= STEP_LIMIT && osc_step != '0 && osc_gain != '0;
    endfunction

    function automatic t_osc_result osc_apply(t_stim_row item);
        t_osc_result        r;
        logic [INDEX_W-1:0] i0;
        logic [INDEX_W-1:0] i1;
        longint             v0;
        longint             v1;
        longint             frac;
        longint             val;
        longint             total;
        total = 0;
        case (item.op)
            OP_LOAD: begin
                wave_mem[item.idx]   = item.value;
                wave_known[item.idx] = 1'b1;
            end
            OP_SET: osc_phase = item.start;
            OP_SAMPLE: begin
                total = longint'(item.accum);
                if (osc_reads_table()) begin
                    i0    = osc_phase[PHASE_BITS-1 -: TABLE_BITS];
                    i1    = i0 + 1'b1;
                    v0    = longint'(wave_mem[i0]);
                    v1    = longint'(wave_mem[i1]);
                    frac  = longint'(osc_phase[FRAC_BITS-1:0]);
                    val   = v0 + (((v1 - v0) * frac) >>> FRAC_BITS);
                    total = total + ((val * longint'(osc_gain)) >>> AMP_FRAC);
                    if (total > SAT_HI) total = SAT_HI;
                    if (total < SAT_LO) total = SAT_LO;
                    if (total > longint'(osc_peak)) osc_peak = total[SAMPLE_W-1:0];
                    osc_phase = osc_phase + osc_step;
                end
            end
            default: ;
        endcase
        r.sample_out = total[SAMPLE_W-1:0];
        r.peak       = osc_peak;
        r.phase_out  = osc_phase;
        r.step_error = (osc_step >> FRAC_BITS) > STEP_LIMIT;
        return r;
    endfunction

    function automatic t_stim_row item_row(t_op op, logic [INDEX_W-1:0] idx,
                                           logic signed [VALUE_W-1:0] value,
                                           logic [PHASE_BITS-1:0] start,
                                           logic signed [SAMPLE_W-1:0] accum);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_ITEM;
        row.op    = op;
        row.idx   = idx;
        row.value = value;
        row.start = start;
        row.accum = accum;
        return row;
    endfunction

    function automatic t_stim_row checked_row(t_op op, logic [INDEX_W-1:0] idx,
                                              logic signed [VALUE_W-1:0] value,
                                              logic [PHASE_BITS-1:0] start,
                                              logic signed [SAMPLE_W-1:0] accum,
                                              logic signed [SAMPLE_W-1:0] w_sample,
                                              logic signed [SAMPLE_W-1:0] w_peak,
                                              logic [PHASE_BITS-1:0] w_phase,
                                              logic w_err);
        t_stim_row row;
        row       = item_row(op, idx, value, start, accum);
        row.typed = 1'b1;
        row.want  = '{w_sample, w_peak, w_phase, w_err};
        return row;
    endfunction

    function automatic t_stim_row reg_row(t_cfg_idx index, logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_idx = index;
        row.data    = data;
        return row;
    endfunction

    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (osc_outputs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(t_stim_row row);
        int          gap;
        t_osc_result due;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= row.op;
        in_if.table_index <= row.idx;
        in_if.table_value <= row.value;
        in_if.start_phase <= row.start;
        in_if.accum_in    <= row.accum;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        due = osc_apply(row);
        osc_outputs_due.push_back(row.typed ? row.want : due);
    endtask

    task automatic write_register(t_cfg_idx index, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        if (index == REG_PHASE_STEP) osc_step = data;
        else osc_gain = data[AMP_W-1:0];
    endtask

    task automatic configure_phase(int p);
        logic [CFG_DATA_W-1:0] step;
        logic [CFG_DATA_W-1:0] gain;
        gain = CFG_DATA_W'($urandom);
        case (p)
            0:       step = CFG_DATA_W'($urandom_range(1, 32'h0000_FFFF));
            2:       step = 26'h200_0000;
            3:       step = CFG_DATA_W'($urandom_range(1, 32'h0004_0000));
            4:       step = CFG_DATA_W'($urandom_range(32'h0201_0000, 32'h03FF_FFFF));
            6:       step = 26'h200_FFFF;
            7:       step = CFG_DATA_W'($urandom_range(1, 32'h0000_FFFF));
            8:       step = 26'h000_0001;
            default: step = CFG_DATA_W'($urandom_range(1, 32'h0200_0000));
        endcase
        case (p)
            0:       gain = CFG_DATA_W'(AMP_RESET);
            2, 7:    gain = 26'h000_FFFF;
            3:       gain = 26'h000_0000;
            5:       gain = 26'h000_0001;
            default: ;
        endcase
        write_register(REG_PHASE_STEP, step);
        write_register(REG_AMPLITUDE, gain);
    endtask

    task automatic send_random_item(bit wide_sums);
        t_stim_row          row;
        int                 pick;
        logic [INDEX_W-1:0] i0;
        logic [INDEX_W-1:0] i1;
        row = item_row(OP_SAMPLE, INDEX_W'($urandom), VALUE_W'($urandom),
                       PHASE_BITS'($urandom), '0);
        pick = $urandom_range(0, 99);
        if (pick < 22) row.op = OP_LOAD;
        else if (pick < 30) row.op = OP_SET;
        else if (pick < 33) row.op = OP_UNUSED;
        if ($urandom_range(0, 15) == 0) row.idx = $urandom_range(0, 1) ? '1 : '0;
        case ($urandom_range(0, 9))
            0:       row.accum = wide_sums ? $urandom : 32'h7FFF_FFFF;
            1:       row.accum = wide_sums ? $urandom : 32'h8000_0000;
            2, 3:    row.accum = wide_sums ? $urandom : $urandom_range(0, 255);
            default: row.accum = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        endcase
        // keep the model and the block away from table entries not loaded yet
        if (row.op == OP_SAMPLE && osc_reads_table()) begin
            i0 = osc_phase[PHASE_BITS-1 -: TABLE_BITS];
            i1 = i0 + 1'b1;
            if (!wave_known[i0]) begin
                row.op  = OP_LOAD;
                row.idx = i0;
            end else if (!wave_known[i1]) begin
                row.op  = OP_LOAD;
                row.idx = i1;
            end
        end
        send_item(row);
    endtask

    initial begin : stimulus
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.op          = OP_LOAD;
        in_if.table_index = '0;
        in_if.table_value = '0;
        in_if.start_phase = '0;
        in_if.accum_in    = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_PHASE_STEP;
        cfg_if.data       = '0;
        out_if.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = {
            checked_row(OP_LOAD,   10'd0,    16'h7FFF, 26'h0,       32'h0,
                        32'h0, 32'h0, 26'h0, 1'b0),
            checked_row(OP_LOAD,   10'd1023, 16'h8000, 26'h0,       32'h0,
                        32'h0, 32'h0, 26'h0, 1'b0),
            checked_row(OP_LOAD,   10'd1,    16'h8000, 26'h0,       32'h0,
                        32'h0, 32'h0, 26'h0, 1'b0),
            checked_row(OP_LOAD,   10'd2,    16'h0000, 26'h0,       32'h0,
                        32'h0, 32'h0, 26'h0, 1'b0),
            checked_row(OP_UNUSED, 10'd5,    16'h04D2, 26'h3FF_FFFF, 32'hFFFF_FFFF,
                        32'h0, 32'h0, 26'h0, 1'b0),
            // step still zero: sums pass straight through
            checked_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h0, 26'h0, 1'b0),
            checked_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0, 32'h8000_0000,
                        32'h8000_0000, 32'h0, 26'h0, 1'b0),
            checked_row(OP_SET, 10'd0, 16'h0, 26'h3FF_FFFF, 32'h0,
                        32'h0, 32'h0, 26'h3FF_FFFF, 1'b0),
            reg_row(REG_PHASE_STEP, 26'h001_0000),
            item_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0,       32'h0),  // last entry to entry 0
            reg_row(REG_AMPLITUDE, 26'h000_FFFF),
            item_row(OP_SET,    10'd0, 16'h0, 26'h0,       32'h0),
            item_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0,       32'h8000_0000),
            item_row(OP_SET,    10'd0, 16'h0, 26'h001_8000, 32'h0),
            item_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0,       32'h8000_0000),  // saturates low
            item_row(OP_SET,    10'd0, 16'h0, 26'h0,       32'h0),
            reg_row(REG_PHASE_STEP, 26'h200_0000),
            item_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0,       32'h0000_0040),
            reg_row(REG_PHASE_STEP, 26'h201_0000),
            item_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0,       32'h0000_3039),
            reg_row(REG_PHASE_STEP, 26'h3FF_FFFF),
            item_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0,       32'hFFFF_FFFB),
            reg_row(REG_PHASE_STEP, 26'h001_0000),
            reg_row(REG_AMPLITUDE, 26'h000_0000),
            item_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0,       32'h0000_0309),
            reg_row(REG_AMPLITUDE, 26'h3FF_0001),
            item_row(OP_SET,    10'd0, 16'h0, 26'h000_FFFF, 32'h0),
            item_row(OP_SAMPLE, 10'd0, 16'h0, 26'h0,       32'h0),
            reg_row(REG_AMPLITUDE, 26'h000_1000)
        };

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_REG) begin
                write_register(dir_rows[n].reg_idx, dir_rows[n].data);
            end else begin
                send_item(dir_rows[n]);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            configure_phase(p);
            repeat (ITEMS_PER_PHASE) send_random_item(p == RAND_PHASES - 1);
        end

        wait_drained();
        if (fail_count == 0 && osc_outputs_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        forever begin
            stall = draw_wait(take_burst);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && out_if.valid === 1'b1));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_osc_result got;
        t_osc_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = '{out_if.sample_out, out_if.peak, out_if.phase_out, out_if.step_error};
            if (osc_outputs_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: sample %h peak %h phase %h err %b",
                             got.sample_out, got.peak, got.phase_out, got.step_error);
            end else begin
                want = osc_outputs_due.pop_front();
                if (got.sample_out !== want.sample_out || got.peak !== want.peak ||
                    got.phase_out !== want.phase_out || got.step_error !== want.step_error) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: sample %h/%h peak %h/%h phase %h/%h err %b/%b",
                                 want.sample_out, got.sample_out, want.peak, got.peak,
                                 want.phase_out, got.phase_out,
                                 want.step_error, got.step_error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/wto_pkg.sv
hw/rtl/wto_if.sv
hw/rtl/wavetable_oscillator_interp.sv
bench/wavetable_oscillator_interp_tb.sv
